// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- rtl/ods_pkg.sv -----
// ----------------------------------------------------------------------------
// ods_pkg
// Types and constants of the stub optical drive controller.
// ----------------------------------------------------------------------------
package ods_pkg;

    localparam int ODS_CMD_DEPTH = 16;
    localparam int RESP_DEPTH    = 4;

    localparam logic [15:0] DELAY_START = 16'd20000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } ods_opcode_t;

    // Register indexes.
    localparam logic [1:0] REG_CMD   = 2'd0;
    localparam logic [1:0] REG_ISSUE = 2'd1;
    localparam logic [1:0] REG_MASK  = 2'd2;
    localparam logic [1:0] REG_IRQ   = 2'd3;

    // Command codes.
    localparam logic [7:0] CMD_GETSTAT = 8'h01;
    localparam logic [7:0] CMD_SETLOC  = 8'h02;
    localparam logic [7:0] CMD_READN   = 8'h06;
    localparam logic [7:0] CMD_SEEK07  = 8'h07;
    localparam logic [7:0] CMD_SEEK08  = 8'h08;
    localparam logic [7:0] CMD_SEEK09  = 8'h09;
    localparam logic [7:0] CMD_SEEK0A  = 8'h0A;
    localparam logic [7:0] CMD_SEEK0C  = 8'h0C;
    localparam logic [7:0] CMD_SETMODE = 8'h0E;
    localparam logic [7:0] CMD_SEEK15  = 8'h15;
    localparam logic [7:0] CMD_SEEK16  = 8'h16;
    localparam logic [7:0] CMD_GETID   = 8'h1A;
    localparam logic [7:0] CMD_SEEK1B  = 8'h1B;

    // Interrupt numbers.
    localparam logic [2:0] IRQ_NONE     = 3'd0;
    localparam logic [2:0] IRQ_COMPLETE = 3'd2;
    localparam logic [2:0] IRQ_ACK      = 3'd3;
    localparam logic [2:0] IRQ_ERROR    = 3'd5;

    // Response and status bytes.
    localparam logic [7:0] STAT_MOTOR_ON = 8'h02;
    localparam logic [7:0] RESP_NODISC   = 8'h80;
    localparam logic [7:0] STAT_ERROR    = 8'h40;
    localparam logic [7:0] ERR_BAD_CMD   = 8'h10;
    localparam logic [7:0] ACK_MASK      = 8'hE0;
    localparam logic [7:0] STATUS_READ   = 8'hE0;

    typedef struct packed {
        ods_opcode_t opcode;
        logic [1:0]  reg_addr;
        logic [7:0]  write_data;
        logic [9:0]  tick_cycles;
    } ods_item_t;

    typedef struct packed {
        logic       irq_pulse;
        logic [7:0] read_data;
    } ods_result_t;

endpackage

// ----- rtl/ods_core.sv -----
// ----------------------------------------------------------------------------
// ods_core
// Controller state and the combinational decode of one bus access or tick.
// ----------------------------------------------------------------------------
module ods_core #(
    parameter int CMD_DEPTH = ods_pkg::ODS_CMD_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ods_pkg::ods_item_t  item,
    output ods_pkg::ods_result_t result
);
    import ods_pkg::*;

    localparam int CNT_W = $clog2(CMD_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CMD_DEPTH);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       first_reg, first_next;
    logic [2:0]       len_reg, len_next;
    logic [2:0]       pos_reg, pos_next;
    logic [2:0]       pend_reg, pend_next;
    logic [15:0]      delay_reg, delay_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       resp_mem_reg [RESP_DEPTH];

    logic [7:0]       cmd_bytes [RESP_DEPTH];
    logic [2:0]       cmd_len;
    logic [2:0]       cmd_irq;
    logic [7:0]       cmd_status;
    logic             run;

    // Response of the first queued byte, should it be issued now.
    always_comb
    begin
        cmd_status = status_reg;
        cmd_bytes[0] = 8'h00;
        cmd_bytes[1] = 8'h00;
        cmd_bytes[2] = 8'h00;
        cmd_bytes[3] = 8'h00;
        case (first_reg)
            CMD_GETSTAT:
            begin
                cmd_status   = STAT_MOTOR_ON;
                cmd_bytes[0] = STAT_MOTOR_ON;
                cmd_len      = 3'd1;
                cmd_irq      = IRQ_ACK;
            end
            CMD_SETLOC, CMD_READN, CMD_GETID:
            begin
                cmd_bytes[0] = RESP_NODISC;
                cmd_len      = 3'd4;
                cmd_irq      = IRQ_ERROR;
            end
            CMD_SETMODE:
            begin
                cmd_bytes[0] = status_reg;
                cmd_len      = 3'd1;
                cmd_irq      = IRQ_ACK;
            end
            CMD_SEEK07, CMD_SEEK08, CMD_SEEK09, CMD_SEEK0A,
            CMD_SEEK0C, CMD_SEEK15, CMD_SEEK16, CMD_SEEK1B:
            begin
                // The completion interrupt replaces the acknowledge at once.
                cmd_bytes[0] = status_reg;
                cmd_bytes[1] = status_reg;
                cmd_len      = 3'd2;
                cmd_irq      = IRQ_COMPLETE;
            end
            default:
            begin
                cmd_bytes[0] = STAT_ERROR | status_reg;
                cmd_bytes[1] = ERR_BAD_CMD;
                cmd_len      = 3'd4;
                cmd_irq      = IRQ_ERROR;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        delay_next  = delay_reg;
        status_next = status_reg;
        run         = 1'b0;
        result      = '0;
        case (item.opcode)
            OP_WRITE:
            begin
                case (item.reg_addr)
                    REG_CMD:
                    begin
                        if (count_reg < CNT_MAX)
                        begin
                            if (count_reg == '0)
                                first_next = item.write_data;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REG_ISSUE:
                    begin
                        if (count_reg != '0)
                        begin
                            run         = 1'b1;
                            count_next  = '0;
                            len_next    = cmd_len;
                            pos_next    = 3'd0;
                            pend_next   = cmd_irq;
                            delay_next  = DELAY_START;
                            status_next = cmd_status;
                        end
                    end
                    REG_IRQ:
                    begin
                        if ((item.write_data & ACK_MASK) != 8'h00)
                        begin
                            pend_next = IRQ_NONE;
                            len_next  = 3'd0;
                            pos_next  = 3'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_READ:
            begin
                case (item.reg_addr)
                    REG_CMD, REG_MASK:
                        result.read_data = STATUS_READ;
                    REG_ISSUE:
                    begin
                        if (pos_reg < len_reg)
                        begin
                            result.read_data = resp_mem_reg[pos_reg[1:0]];
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        result.read_data = {5'd0, pend_reg};
                        if (pend_reg != IRQ_NONE)
                        begin
                            result.irq_pulse = 1'b1;
                            pend_next = IRQ_NONE;
                        end
                    end
                endcase
            end
            OP_TICK:
            begin
                if (delay_reg != 16'd0)
                begin
                    if ({6'd0, item.tick_cycles} >= delay_reg)
                    begin
                        delay_next = 16'd0;
                        result.irq_pulse = (pend_reg != IRQ_NONE);
                    end
                    else
                    begin
                        delay_next = delay_reg - {6'd0, item.tick_cycles};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            first_reg  <= 8'h00;
            len_reg    <= 3'd0;
            pos_reg    <= 3'd0;
            pend_reg   <= IRQ_NONE;
            delay_reg  <= 16'd0;
            status_reg <= 8'h00;
        end
        else if (fire)
        begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            delay_reg  <= delay_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && run)
        begin
            for (int i = 0; i < RESP_DEPTH; i++)
                resp_mem_reg[i] <= cmd_bytes[i];
        end
    end

endmodule

// ----- rtl/optical_drive_stub_controller.sv -----
// ----------------------------------------------------------------------------
// optical_drive_stub_controller
// Stub optical drive controller with no disc, behind four byte registers.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result stream is not stalled, and
// returns exactly one result per request. The rate is set by the register
// decode and state update. A request is captured in an input register at the
// edge that accepts it. The decode runs from that register once the output
// register is free or being emptied, and the result is captured in the output
// register. While a result waits for tready, one more request can enter the
// input register. After that, s_axis_tready stays low until the waiting
// result is taken.
`include "assert_macros.svh"

module optical_drive_stub_controller #(
    parameter int CMD_DEPTH = ods_pkg::ODS_CMD_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_addr[1:0], write_data[9:2], tick_cycles[19:10], zero pad[23:20]
    input  logic [23:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], irq_pulse[8], zero pad[15:9]
    output logic [15:0] m_axis_tdata
);
    import ods_pkg::*;

    logic        in_valid_reg, in_valid_next;
    ods_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    ods_result_t out_reg;
    ods_result_t result;
    logic        s_fire;
    logic        advance;
    logic        core_fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign core_fire     = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (core_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.opcode      <= ods_opcode_t'(s_axis_tuser);
            item_reg.reg_addr    <= s_axis_tdata[1:0];
            item_reg.write_data  <= s_axis_tdata[9:2];
            item_reg.tick_cycles <= s_axis_tdata[19:10];
        end
        if (core_fire)
            out_reg <= result;
    end

    ods_core #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (core_fire),
        .item   (item_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.irq_pulse, out_reg.read_data};

    `ASSERT_CLK(a_held_request_stays, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg)
    `ASSERT_CLK(a_decode_gives_result, clk, rst_n, core_fire |=> m_axis_tvalid)
    `ASSERT_NEVER(a_stall_needs_full, clk, rst_n, !s_axis_tready && !(in_valid_reg && out_valid_reg))

endmodule

// ----- tb/optical_drive_stub_controller_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_drive_stub_controller_test
// Streams bus writes, bus reads and time ticks into the stub drive controller
// and checks each returned byte and interrupt pulse against a predictor of
// the command queue, response store and interrupt timer, with random gaps
// and stalls on both streams.
// ----------------------------------------------------------------------------
module optical_drive_stub_controller_test;
    import ods_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_ITEMS   = 800;
    localparam int DRAIN_CYCLES   = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // reg_addr[1:0], write_data[9:2], tick_cycles[19:10], zero pad[23:20]
    logic [23:0] s_axis_tdata;
    // opcode[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // read_data[7:0], irq_pulse[8], zero pad[15:9]
    logic [15:0] m_axis_tdata;

    optical_drive_stub_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted drive state.
    logic [4:0]  queued_cmds;
    logic [7:0]  head_cmd;
    logic [7:0]  resp_store [RESP_DEPTH];
    logic [2:0]  resp_fill;
    logic [2:0]  resp_rdptr;
    logic [2:0]  pending_irq;
    logic [15:0] irq_delay;
    logic [7:0]  status_byte;

    ods_result_t expected_results [$];
    int          failures;
    int          requests_sent;
    int          cycle_count;
    bit          drive_steady;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void reset_drive_model();
        queued_cmds = '0;
        head_cmd    = '0;
        resp_fill   = '0;
        resp_rdptr  = '0;
        pending_irq = IRQ_NONE;
        irq_delay   = '0;
        status_byte = '0;
        for (int i = 0; i < RESP_DEPTH; i++)
            resp_store[i] = '0;
    endfunction

    function automatic void push_response(input logic [7:0] b);
        if (resp_fill < RESP_DEPTH)
        begin
            resp_store[resp_fill[1:0]] = b;
            resp_fill = resp_fill + 1'b1;
        end
    endfunction

    function automatic void raise_irq(input logic [2:0] num);
        pending_irq = num;
        irq_delay   = DELAY_START;
    endfunction

    function automatic void execute_command(input logic [7:0] cmd);
        resp_fill  = '0;
        resp_rdptr = '0;
        case (cmd)
            CMD_GETSTAT:
            begin
                status_byte = STAT_MOTOR_ON;
                push_response(status_byte);
                raise_irq(IRQ_ACK);
            end
            CMD_SETLOC, CMD_READN, CMD_GETID:
            begin
                push_response(RESP_NODISC);
                push_response(8'h00);
                push_response(8'h00);
                push_response(8'h00);
                raise_irq(IRQ_ERROR);
            end
            CMD_SETMODE:
            begin
                push_response(status_byte);
                raise_irq(IRQ_ACK);
            end
            CMD_SEEK07, CMD_SEEK08, CMD_SEEK09, CMD_SEEK0A,
            CMD_SEEK0C, CMD_SEEK15, CMD_SEEK16, CMD_SEEK1B:
            begin
                // The completion interrupt replaces the acknowledge at once.
                push_response(status_byte);
                raise_irq(IRQ_ACK);
                push_response(status_byte);
                raise_irq(IRQ_COMPLETE);
            end
            default:
            begin
                push_response(STAT_ERROR | status_byte);
                push_response(ERR_BAD_CMD);
                push_response(8'h00);
                push_response(8'h00);
                raise_irq(IRQ_ERROR);
            end
        endcase
    endfunction

    function automatic ods_result_t drive_model_step(input ods_opcode_t op,
                                                     input logic [1:0] ra,
                                                     input logic [7:0] wd,
                                                     input logic [9:0] tc);
        ods_result_t res;
        res = '0;
        case (op)
            OP_WRITE:
            begin
                if (ra == REG_CMD)
                begin
                    if (queued_cmds < ODS_CMD_DEPTH)
                    begin
                        if (queued_cmds == 0)
                            head_cmd = wd;
                        queued_cmds = queued_cmds + 1'b1;
                    end
                end
                else if (ra == REG_ISSUE)
                begin
                    if (queued_cmds != 0)
                    begin
                        execute_command(head_cmd);
                        queued_cmds = '0;
                    end
                end
                else if (ra == REG_IRQ)
                begin
                    if ((wd & ACK_MASK) != 0)
                    begin
                        pending_irq = IRQ_NONE;
                        resp_fill   = '0;
                        resp_rdptr  = '0;
                    end
                end
            end
            OP_READ:
            begin
                if (ra == REG_CMD || ra == REG_MASK)
                    res.read_data = STATUS_READ;
                else if (ra == REG_ISSUE)
                begin
                    if (resp_rdptr < resp_fill)
                    begin
                        res.read_data = resp_store[resp_rdptr[1:0]];
                        resp_rdptr = resp_rdptr + 1'b1;
                    end
                end
                else
                begin
                    res.read_data = {5'b0, pending_irq};
                    if (pending_irq != IRQ_NONE)
                    begin
                        res.irq_pulse = 1'b1;
                        pending_irq   = IRQ_NONE;
                    end
                end
            end
            OP_TICK:
            begin
                if (irq_delay != 0)
                begin
                    if ({6'b0, tc} >= irq_delay)
                    begin
                        irq_delay = '0;
                        if (pending_irq != IRQ_NONE)
                            res.irq_pulse = 1'b1;
                    end
                    else
                        irq_delay = irq_delay - {6'b0, tc};
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Leaves tvalid high after acceptance so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_request(input ods_opcode_t op, input logic [1:0] ra,
                                input logic [7:0] wd, input logic [9:0] tc);
        int gap;
        gap = drive_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, tc, wd, ra};
        do @(posedge clk); while (!s_axis_tready);
        expected_results.push_back(drive_model_step(op, ra, wd, tc));
        requests_sent++;
    endtask

    function automatic logic [7:0] pick_known_command();
        case ($urandom_range(0, 12))
            0:       return CMD_GETSTAT;
            1:       return CMD_SETLOC;
            2:       return CMD_READN;
            3:       return CMD_SEEK07;
            4:       return CMD_SEEK08;
            5:       return CMD_SEEK09;
            6:       return CMD_SEEK0A;
            7:       return CMD_SEEK0C;
            8:       return CMD_SETMODE;
            9:       return CMD_SEEK15;
            10:      return CMD_SEEK16;
            11:      return CMD_GETID;
            default: return CMD_SEEK1B;
        endcase
    endfunction

    // Reads, writes and a tick that touch no command, plus an unused opcode.
    task automatic test_idle_registers();
        send_request(OP_READ,  REG_CMD,   8'h00, 10'd0);
        send_request(OP_READ,  REG_MASK,  8'hFF, 10'd1023);
        send_request(OP_READ,  REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_READ,  REG_IRQ,   8'h00, 10'd0);
        send_request(OP_NONE,  REG_IRQ,   8'hFF, 10'd1023);
        send_request(OP_WRITE, REG_MASK,  8'hFF, 10'd0);
        send_request(OP_WRITE, REG_IRQ,   8'h1F, 10'd0);
        send_request(OP_WRITE, REG_ISSUE, 8'hFF, 10'd0);
        send_request(OP_TICK,  REG_CMD,   8'h00, 10'd1023);
    endtask

    // Issue, response pops, a tick, interrupt read, a full queue and an acknowledge.
    task automatic test_command_queue();
        send_request(OP_WRITE, REG_CMD,   CMD_GETSTAT, 10'd0);
        send_request(OP_WRITE, REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_READ,  REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_READ,  REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_TICK,  REG_CMD,   8'h00, 10'd0);
        send_request(OP_READ,  REG_IRQ,   8'h00, 10'd0);
        send_request(OP_WRITE, REG_CMD,   CMD_SETMODE, 10'd0);
        repeat (ODS_CMD_DEPTH - 1)
            send_request(OP_WRITE, REG_CMD, 8'hFF, 10'd0);
        // The queue is full now, so this byte is dropped.
        send_request(OP_WRITE, REG_CMD,   8'h00, 10'd0);
        send_request(OP_WRITE, REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_READ,  REG_ISSUE, 8'h00, 10'd0);
        send_request(OP_WRITE, REG_IRQ,   ACK_MASK, 10'd0);
        send_request(OP_READ,  REG_ISSUE, 8'h00, 10'd0);
    endtask

    task automatic run_command_sequence();
        logic [7:0] cmd;
        int         extra;
        cmd   = ($urandom_range(0, 9) < 7) ? pick_known_command() : 8'($urandom);
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 2);
        send_request(OP_WRITE, REG_CMD, cmd, 10'($urandom));
        repeat (extra)
            send_request(OP_WRITE, REG_CMD, 8'($urandom), 10'($urandom));
        if ($urandom_range(0, 9) != 0)
            send_request(OP_WRITE, REG_ISSUE, 8'($urandom), 10'($urandom));
        repeat ($urandom_range(0, 5))
            send_request(OP_READ, REG_ISSUE, 8'($urandom), 10'($urandom));
        case ($urandom_range(0, 3))
            0: send_request(OP_READ, REG_IRQ, 8'($urandom), 10'($urandom));
            1:
            begin
                while (irq_delay != 0)
                    send_request(OP_TICK, 2'($urandom), 8'($urandom),
                                 10'($urandom_range(500, 1023)));
                if ($urandom_range(0, 1) == 0)
                    send_request(OP_READ, REG_IRQ, 8'($urandom), 10'($urandom));
            end
            2: send_request(OP_WRITE, REG_IRQ, 8'($urandom), 10'($urandom));
            default: ;
        endcase
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = requests_sent + RANDOM_ITEMS;
        while (requests_sent < stop_at)
        begin
            drive_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
                run_command_sequence();
            else
                repeat ($urandom_range(1, 4))
                    send_request(ods_opcode_t'($urandom_range(0, 3)), 2'($urandom),
                                 8'($urandom), 10'($urandom));
        end
        drive_steady = 1'b0;
    endtask

    // Result side: random stalls, with an occasional long ready stretch.
    initial
    begin
        int run;
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                run = $urandom_range(50, 150);
                gap = 0;
            end
            else
            begin
                run = $urandom_range(1, 20);
                gap = pick_gap();
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        ods_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: read_data %0h irq_pulse %0b",
                       m_axis_tdata[7:0], m_axis_tdata[8]);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[7:0] !== want.read_data)
                begin
                    $error("read_data: expected %0h, got %0h",
                           want.read_data, m_axis_tdata[7:0]);
                    failures++;
                end
                if (m_axis_tdata[8] !== want.irq_pulse)
                begin
                    $error("irq_pulse: expected %0b, got %0b",
                           want.irq_pulse, m_axis_tdata[8]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        failures      = 0;
        requests_sent = 0;
        cycle_count   = 0;
        drive_steady  = 1'b0;
        reset_drive_model();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_NONE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_registers();
        test_command_queue();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ods_pkg.sv
rtl/ods_core.sv
rtl/optical_drive_stub_controller.sv
tb/optical_drive_stub_controller_test.sv
